// File: rtl/core/aesd_pkg.sv
// Shared types, tables and GF(2^8) helpers for the AES-128 decrypt core.
// Depends on nothing; used by the controller, the datapath and the top level.
package aesd_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned RkDepth   = NumRounds + 1;
    localparam int unsigned RkAddrW   = $clog2(RkDepth);

    typedef logic [127:0]        t_block;
    typedef logic [RkAddrW-1:0]  t_rk_addr;

    // Round operation applied to the state register
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ADDKEY,
        OP_FULL,
        OP_LAST
    } t_round_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      rk_we;
        t_rk_addr  rk_waddr;
        t_rk_addr  rk_raddr;
        logic      ek_first;
        logic      load_ct;
        t_round_op op;
        logic      load_out;
    } t_cmd;

    // Forward S-box, entry 0 in the top byte
    localparam logic [2047:0] SBOX = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    // Invert the forward table at elaboration
    function automatic logic [2047:0] build_inv();
        logic [2047:0] inv;
        logic [7:0]    fwd;
        inv = '0;
        for (int i = 0; i < 256; i++) begin
            fwd = SBOX[2047 - 8*i -: 8];
            inv[2047 - 8*int'(fwd) -: 8] = 8'(i);
        end
        return inv;
    endfunction

    localparam logic [2047:0] INV_SBOX = build_inv();

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[11'd2047 - {x, 3'b000} -: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX[11'd2047 - {x, 3'b000} -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Round constant for the key that follows round key k
    function automatic logic [7:0] rcon(input t_rk_addr k);
        logic [7:0] r;
        case (k)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // One step of the AES-128 key schedule: round key k to round key k+1
    function automatic t_block next_rk(input t_block key, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = key[127:96];
        w1 = key[95:64];
        w2 = key[63:32];
        w3 = key[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // Inverse shift rows followed by inverse substitution; byte k at bits 127-8k
    function automatic t_block inv_shift_sub(input t_block s);
        t_block o;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                o[127 - 8*(r + 4*((c + r) % 4)) -: 8] = inv_sbox(s[127 - 8*(r + 4*c) -: 8]);
            end
        end
        return o;
    endfunction

    function automatic t_block inv_mix(input t_block s);
        t_block o;
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] x9 [4];
        logic [7:0] xb [4];
        logic [7:0] xd [4];
        logic [7:0] xe [4];
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = s[127 - 8*(4*c + j) -: 8];
                m2[j] = xt(a[j]);
                m4[j] = xt(m2[j]);
                m8[j] = xt(m4[j]);
                x9[j] = m8[j] ^ a[j];
                xb[j] = m8[j] ^ m2[j] ^ a[j];
                xd[j] = m8[j] ^ m4[j] ^ a[j];
                xe[j] = m8[j] ^ m4[j] ^ m2[j];
            end
            o[127 - 8*(4*c)     -: 8] = xe[0] ^ xb[1] ^ xd[2] ^ x9[3];
            o[127 - 8*(4*c + 1) -: 8] = x9[0] ^ xe[1] ^ xb[2] ^ xd[3];
            o[127 - 8*(4*c + 2) -: 8] = xd[0] ^ x9[1] ^ xe[2] ^ xb[3];
            o[127 - 8*(4*c + 3) -: 8] = xb[0] ^ xd[1] ^ x9[2] ^ xe[3];
        end
        return o;
    endfunction

endpackage

// File: rtl/core/aesd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module aesd_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/aesd_ctrl.sv
// Controller for the AES-128 decrypt core: key expansion, rounds, output slot.
// Depends on aesd_pkg; drives the datapath through a t_cmd struct.
module aesd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output aesd_pkg::t_cmd o_cmd
);
    import aesd_pkg::*;

    typedef enum logic [2:0] {
        S_EXPAND,
        S_SETTLE,
        S_IDLE,
        S_ROUND,
        S_DONE
    } t_state;

    localparam t_rk_addr LastRk = t_rk_addr'(NumRounds);

    t_state   r_state, n_state;
    t_rk_addr r_cnt, n_cnt;
    logic     r_out_valid, n_out_valid;
    t_cmd     cmd;

    // Decode state into datapath commands and next state
    always_comb begin
        cmd         = '0;
        cmd.op      = OP_HOLD;
        cmd.rk_raddr = LastRk;
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_in_ready  = 1'b0;
        case (r_state)
            S_EXPAND: begin
                cmd.rk_we    = 1'b1;
                cmd.rk_waddr = r_cnt;
                cmd.ek_first = (r_cnt == '0);
                if (r_cnt == LastRk) begin
                    n_state = S_SETTLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SETTLE: begin
                n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = !i_cfg_we;
                if (i_in_valid && !i_cfg_we) begin
                    cmd.load_ct = 1'b1;
                    n_state     = S_ROUND;
                    n_cnt       = LastRk;
                end
            end
            S_ROUND: begin
                if (r_cnt != '0) begin
                    cmd.rk_raddr = r_cnt - 1'b1;
                end
                if (r_cnt == LastRk) begin
                    cmd.op = OP_ADDKEY;
                end else if (r_cnt == '0) begin
                    cmd.op = OP_LAST;
                end else begin
                    cmd.op = OP_FULL;
                end
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_EXPAND;
                n_cnt   = '0;
            end
        endcase
        // A key write restarts the schedule
        if (i_cfg_we) begin
            n_state = S_EXPAND;
            n_cnt   = '0;
        end
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold state, round counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXPAND;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    // Round counter stays within the round key range
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LastRk)
        else $error("round counter out of range");

    // An accepted block starts with the last round key
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_ROUND && r_cnt == LastRk))
        else $error("block did not start at last round key");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output slot overwritten");

    // Round key store is written only during expansion
    a_rk_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rk_we |-> (r_state == S_EXPAND && !o_in_ready))
        else $error("round key write outside expansion");

endmodule

// File: rtl/core/aesd_dp.sv
// Datapath for the AES-128 decrypt core: key registers, key schedule,
// round key store, state register and output register. Depends on aesd_pkg, aesd_ram.
module aesd_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [63:0]    i_cfg_data,
    input  aesd_pkg::t_cmd i_cmd,
    input  logic [63:0]    i_ciphertext_hi,
    input  logic [63:0]    i_ciphertext_lo,
    output logic [63:0]    o_plaintext_hi,
    output logic [63:0]    o_plaintext_lo
);
    import aesd_pkg::*;

    localparam logic IdxKeyHi = 1'b0;
    localparam logic IdxKeyLo = 1'b1;

    logic [63:0] r_key_hi, r_key_lo;
    t_block      r_ek;
    t_block      r_state, n_state;
    t_block      r_out;
    t_block      rk_wdata, rk_rdata, shifted;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == IdxKeyHi) begin
                r_key_hi <= i_cfg_data;
            end
            if (i_cfg_index == IdxKeyLo) begin
                r_key_lo <= i_cfg_data;
            end
        end
    end

    // Key schedule: store round key k, advance to k+1
    assign rk_wdata = i_cmd.ek_first ? {r_key_hi, r_key_lo} : r_ek;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rk_we) begin
            r_ek <= next_rk(rk_wdata, rcon(i_cmd.rk_waddr));
        end
    end

    aesd_ram #(
        .WIDTH(128),
        .DEPTH(RkDepth)
    ) u_rk_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.rk_we),
        .i_waddr(i_cmd.rk_waddr),
        .i_wdata(rk_wdata),
        .i_raddr(i_cmd.rk_raddr),
        .o_rdata(rk_rdata)
    );

    // One decryption round per cycle
    assign shifted = inv_shift_sub(r_state) ^ rk_rdata;

    always_comb begin
        case (i_cmd.op)
            OP_ADDKEY: n_state = r_state ^ rk_rdata;
            OP_FULL:   n_state = inv_mix(shifted);
            OP_LAST:   n_state = shifted;
            default:   n_state = r_state;
        endcase
        if (i_cmd.load_ct) begin
            n_state = {i_ciphertext_hi, i_ciphertext_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        if (i_cmd.load_out) begin
            r_out <= r_state;
        end
    end

    assign o_plaintext_hi = r_out[127:64];
    assign o_plaintext_lo = r_out[63:0];

endmodule

// File: rtl/core/aes128_block_decrypt_core.sv
// Top level of the AES-128 block decrypt core (ECB, one block per transaction).
// Depends on aesd_pkg, aesd_ctrl, aesd_dp, aesd_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_ready | i_ciphertext_hi, _lo
//   out     | output    | o_out_valid/i_out_ready | o_plaintext_hi, _lo
//   cfg     | input     | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// A block passes through these steps: the accept cycle loads it, eleven round-key
// steps run through a single shared round unit, and a transfer step, held while the
// output slot is still full, moves it to the output register and raises o_out_valid.
// After reset and after each key write the schedule is rebuilt, one round key a
// cycle, followed by a settle state; no block is accepted meanwhile.
// A finished block waits in the output register; a new block may be accepted while
// it waits, and that block stalls before transfer until the output slot frees.
module aes128_block_decrypt_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_ciphertext_hi,
    input  logic [63:0] i_ciphertext_lo,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_plaintext_hi,
    output logic [63:0] o_plaintext_lo
);
    import aesd_pkg::*;

    t_cmd cmd;

    aesd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (cmd)
    );

    aesd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .i_ciphertext_hi(i_ciphertext_hi),
        .i_ciphertext_lo(i_ciphertext_lo),
        .o_plaintext_hi (o_plaintext_hi),
        .o_plaintext_lo (o_plaintext_lo)
    );

endmodule
